### rtl/core/vertex_matrix_transform_assert.svh
// ----------------------------------------------------------------------------
// Vertex matrix transform assertion macros
// Concurrent checks, removed when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef VERTEX_MATRIX_TRANSFORM_ASSERT_SVH
`define VERTEX_MATRIX_TRANSFORM_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define VMT_ASSERT_SAME(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("vertex_matrix_transform check failed");
`define VMT_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("vertex_matrix_transform check failed");
`else
`define VMT_ASSERT_SAME(label, clk, rst, pre, post)
`define VMT_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

### rtl/core/vmt_pkg.sv
// ----------------------------------------------------------------------------
// Vertex matrix transform package
// Word types, matrix entry access and divider pipeline types.
// ----------------------------------------------------------------------------
package vmt_pkg;

  localparam int ROW_W     = 64;
  localparam int ENT_W     = 16;
  localparam int COORD_W   = 32;
  localparam int PROD_W    = COORD_W + ENT_W;
  localparam int ACC_W     = 51;
  localparam int AW        = ACC_W;
  localparam int Q_W       = 32;
  localparam int FRAC_W    = 16;
  localparam int DIR_SHIFT = 12;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3 = 8'd3;

  localparam logic [ROW_W-1:0] ROW0_RST = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW1_RST = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW2_RST = 64'h0000_1000_0000_0000;
  localparam logic [ROW_W-1:0] ROW3_RST = 64'h1000_0000_0000_0000;

  localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic signed [ENT_W-1:0] ent_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic   op;
    coord_t in_x;
    coord_t in_y;
    coord_t in_z;
  } vmt_in_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   w_zero;
    logic   saturated;
  } vmt_out_t;

  typedef struct packed {
    logic               use_fix;
    logic [Q_W-1:0]     fix_val;
    logic               fix_clip;
    logic               neg;
    logic               ovf;
    logic [AW-1:0]      rem;
    logic [FRAC_W-1:0]  nb;
    logic [Q_W-1:0]     q;
  } vmt_lane_t;

  typedef struct packed {
    vmt_lane_t [2:0] lane;
    logic [AW-1:0]   den;
    logic            w_zero;
  } vmt_div_t;

  function automatic ent_t mat_entry(row_t row, logic [1:0] col);
    return row[ENT_W*col +: ENT_W];
  endfunction

endpackage

### rtl/core/vmt_mac.sv
// ----------------------------------------------------------------------------
// Vertex matrix transform multiply-accumulate
// Twelve products in one stage, column sums with translation in the next.
// ----------------------------------------------------------------------------
module vmt_mac (
  input  logic              clk,
  input  logic              en_mul,
  input  logic              en_sum,
  input  vmt_pkg::vmt_in_t  in_word,
  input  vmt_pkg::row_t     matrix [4],
  output vmt_pkg::acc_t     acc [4],
  output logic              op_dir
);
  import vmt_pkg::*;

  coord_t vec [3];
  prod_t  prod [3][4];
  ent_t   tr [4];
  logic   op_mul;

  assign vec[0] = in_word.in_x;
  assign vec[1] = in_word.in_y;
  assign vec[2] = in_word.in_z;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      op_mul <= in_word.op;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod[r][c] <= prod_t'(vec[r]) * prod_t'(mat_entry(matrix[r], 2'(c)));
        end
      end
      // direction words take no translation
      for (int c = 0; c < 4; c++) begin
        tr[c] <= in_word.op ? '0 : mat_entry(matrix[3], 2'(c));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      op_dir <= op_mul;
      for (int c = 0; c < 4; c++) begin
        acc[c] <= acc_t'(prod[0][c]) + acc_t'(prod[1][c]) + acc_t'(prod[2][c])
                + (acc_t'(tr[c]) <<< FRAC_W);
      end
    end
  end

endmodule

### rtl/core/vmt_div_front.sv
// ----------------------------------------------------------------------------
// Vertex matrix transform divider front end
// Signs, magnitudes, overflow test and the results that need no divide.
// ----------------------------------------------------------------------------
module vmt_div_front (
  input  logic              clk,
  input  logic              en,
  input  vmt_pkg::acc_t     acc [4],
  input  logic              op_dir,
  output vmt_pkg::vmt_div_t stage
);
  import vmt_pkg::*;

  vmt_div_t      nxt;
  logic [AW-1:0] den_mag;
  logic [AW-1:0] num_mag;
  logic          w_is_zero;
  acc_t          sh;

  always_comb begin
    nxt       = '0;
    num_mag   = '0;
    sh        = '0;
    w_is_zero = (acc[3] == '0);
    den_mag   = acc[3][ACC_W-1] ? AW'(-acc[3]) : AW'(acc[3]);
    nxt.den    = den_mag;
    nxt.w_zero = !op_dir && w_is_zero;
    for (int l = 0; l < 3; l++) begin
      num_mag = acc[l][ACC_W-1] ? AW'(-acc[l]) : AW'(acc[l]);
      sh      = acc[l] >>> DIR_SHIFT;
      nxt.lane[l].neg = acc[l][ACC_W-1] ^ acc[3][ACC_W-1];
      nxt.lane[l].rem = num_mag >> FRAC_W;
      nxt.lane[l].nb  = num_mag[FRAC_W-1:0];
      nxt.lane[l].ovf = (num_mag >> FRAC_W) >= den_mag;
      nxt.lane[l].q   = '0;
      if (op_dir) begin
        nxt.lane[l].use_fix = 1'b1;
        if (sh > acc_t'(Q_MAX)) begin
          nxt.lane[l].fix_val  = Q_MAX;
          nxt.lane[l].fix_clip = 1'b1;
        end else if (sh < acc_t'(Q_MIN)) begin
          nxt.lane[l].fix_val  = Q_MIN;
          nxt.lane[l].fix_clip = 1'b1;
        end else begin
          nxt.lane[l].fix_val  = sh[Q_W-1:0];
          nxt.lane[l].fix_clip = 1'b0;
        end
      end else if (w_is_zero) begin
        // zero w: clip by sign of the numerator
        nxt.lane[l].use_fix  = 1'b1;
        nxt.lane[l].fix_clip = (acc[l] != '0);
        if (acc[l] == '0) begin
          nxt.lane[l].fix_val = '0;
        end else if (acc[l][ACC_W-1]) begin
          nxt.lane[l].fix_val = Q_MIN;
        end else begin
          nxt.lane[l].fix_val = Q_MAX;
        end
      end else begin
        nxt.lane[l].use_fix  = 1'b0;
        nxt.lane[l].fix_val  = '0;
        nxt.lane[l].fix_clip = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage <= nxt;
    end
  end

endmodule

### rtl/core/vmt_div_stage.sv
// ----------------------------------------------------------------------------
// Vertex matrix transform divider stage
// Restoring division steps on three lanes sharing one divisor.
// ----------------------------------------------------------------------------
module vmt_div_stage #(
  parameter int STEPS = 2
) (
  input  logic              clk,
  input  logic              en,
  input  vmt_pkg::vmt_div_t d_in,
  output vmt_pkg::vmt_div_t d_out
);
  import vmt_pkg::*;

  vmt_div_t    cur;
  logic [AW:0] r2;

  always_comb begin
    cur = d_in;
    r2  = '0;
    for (int s = 0; s < STEPS; s++) begin
      for (int l = 0; l < 3; l++) begin
        r2 = {cur.lane[l].rem, cur.lane[l].nb[FRAC_W-1]};
        cur.lane[l].nb = {cur.lane[l].nb[FRAC_W-2:0], 1'b0};
        if (r2 >= {1'b0, cur.den}) begin
          cur.lane[l].rem = AW'(r2 - {1'b0, cur.den});
          cur.lane[l].q   = {cur.lane[l].q[Q_W-2:0], 1'b1};
        end else begin
          cur.lane[l].rem = AW'(r2);
          cur.lane[l].q   = {cur.lane[l].q[Q_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= cur;
    end
  end

endmodule

### rtl/core/vmt_out.sv
// ----------------------------------------------------------------------------
// Vertex matrix transform output stage
// Sign restore, saturation and the output word register.
// ----------------------------------------------------------------------------
module vmt_out (
  input  logic              clk,
  input  logic              en,
  input  vmt_pkg::vmt_div_t d_in,
  output vmt_pkg::vmt_out_t res
);
  import vmt_pkg::*;

  logic [Q_W-1:0] val [3];
  logic [2:0]     clip;
  logic [Q_W-1:0] limit;

  always_comb begin
    limit = '0;
    for (int l = 0; l < 3; l++) begin
      limit = d_in.lane[l].neg ? Q_MIN : Q_MAX;
      if (d_in.lane[l].use_fix) begin
        val[l]  = d_in.lane[l].fix_val;
        clip[l] = d_in.lane[l].fix_clip;
      end else if (d_in.lane[l].ovf || (d_in.lane[l].q > limit)) begin
        val[l]  = d_in.lane[l].neg ? Q_MIN : Q_MAX;
        clip[l] = 1'b1;
      end else begin
        val[l]  = d_in.lane[l].neg ? Q_W'(-d_in.lane[l].q) : d_in.lane[l].q;
        clip[l] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.out_x     <= val[0];
      res.out_y     <= val[1];
      res.out_z     <= val[2];
      res.w_zero    <= d_in.w_zero;
      res.saturated <= |clip;
    end
  end

endmodule

### rtl/core/vertex_matrix_transform.sv
// ----------------------------------------------------------------------------
// Vertex matrix transform
// 4x4 homogeneous point transform with perspective divide, or 3x3 direction
// transform, on signed Q16.16 vectors with a Q4.12 matrix.
//
//  port group  role      word
//  in_*        input     vmt_in_t: op, in_x, in_y, in_z
//  out_*       output    vmt_out_t: out_x, out_y, out_z, w_zero, saturated
//  cfg_*       config    index 0..3 selects matrix row, 64-bit data
//
// One word per cycle while out_ready holds; the divider is the 32-step
// quotient pipeline, DIV_STEPS_PER_STAGE steps in each divider stage.
// Each stage holds only while it is full and the stage after it holds, so
// bubbles close up under an output stall.
// Synchronous reset clears valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
`include "vertex_matrix_transform_assert.svh"

module vertex_matrix_transform #(
  parameter int DIV_STEPS_PER_STAGE = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  vmt_pkg::vmt_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output vmt_pkg::vmt_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vmt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vmt_pkg::ROW_W-1:0]       cfg_data
);
  import vmt_pkg::*;

  localparam int DIV_STAGES = Q_W / DIV_STEPS_PER_STAGE;
  localparam int NST        = DIV_STAGES + 4;

  row_t     matrix [4];
  acc_t     acc [4];
  logic     op_dir;
  vmt_div_t div_pipe [DIV_STAGES+1];
  logic [NST-1:0] vld;
  logic [NST-1:0] en;
  logic     out_nonzero;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix[0] <= ROW0_RST;
      matrix[1] <= ROW1_RST;
      matrix[2] <= ROW2_RST;
      matrix[3] <= ROW3_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROW0: matrix[0] <= cfg_data;
        REG_ROW1: matrix[1] <= cfg_data;
        REG_ROW2: matrix[2] <= cfg_data;
        REG_ROW3: matrix[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage enables: load when empty or when the next stage moves
  always_comb begin
    en[NST-1] = !vld[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NST-1];

  vmt_mac u_mac (
    .clk    (clk),
    .en_mul (en[0]),
    .en_sum (en[1]),
    .in_word(in_data),
    .matrix (matrix),
    .acc    (acc),
    .op_dir (op_dir)
  );

  vmt_div_front u_front (
    .clk   (clk),
    .en    (en[2]),
    .acc   (acc),
    .op_dir(op_dir),
    .stage (div_pipe[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    vmt_div_stage #(
      .STEPS(DIV_STEPS_PER_STAGE)
    ) u_div (
      .clk  (clk),
      .en   (en[g+3]),
      .d_in (div_pipe[g]),
      .d_out(div_pipe[g+1])
    );
  end

  vmt_out u_out (
    .clk (clk),
    .en  (en[NST-1]),
    .d_in(div_pipe[DIV_STAGES]),
    .res (out_data)
  );

  assign out_nonzero = (out_data.out_x != '0) || (out_data.out_y != '0) ||
                       (out_data.out_z != '0);

  `VMT_ASSERT_SAME(a_full_when_blocked, clk, rst, !in_ready, &vld)
  `VMT_ASSERT_SAME(a_wzero_clips, clk, rst, out_valid && out_data.w_zero && out_nonzero, out_data.saturated)
  `VMT_ASSERT_NEXT(a_row0_write, clk, rst, cfg_valid && cfg_ready && cfg_index == REG_ROW0, matrix[0] == $past(cfg_data))

endmodule
